/* hdl/eslw_pkg.sv */
package eslw_pkg;

    localparam int unsigned DEF_LENGTH_BITS = 24;
    localparam int unsigned WIN_BYTES       = 28;
    localparam int unsigned ATTR_BYTES      = 4;
    localparam int unsigned GUID_BYTES      = 16;
    localparam int unsigned FIRST_HDR_END   = ATTR_BYTES + WIN_BYTES - 1;
    localparam logic [7:0]  X509_TAG        = 8'hA1;

    localparam int unsigned FIFO_DEPTH      = 4;
    localparam int unsigned FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);

    localparam logic KIND_CERT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_TRAILING = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_file;
        logic [23:0] file_length;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [23:0] entry_offset;
        logic [23:0] entry_size;
        logic [23:0] cert_total;
        logic [1:0]  file_status;
        logic        last_result;
    } res_t;

    typedef struct packed {
        logic cert_v;
        logic sum_v;
        res_t cert;
        res_t sum;
    } walk_out_t;

endpackage

/* hdl/eslw_in_if.sv */
interface eslw_in_if import eslw_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/eslw_out_if.sv */
interface eslw_out_if import eslw_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/eslw_cell.sv */
module eslw_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clr,
    input  logic       shift,
    input  logic [7:0] din,
    output logic [7:0] q,
    output logic [7:0] fwd
);

    logic [7:0] q_reg;
    logic [7:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift)
        begin
            q_next = din;
        end
        else if (clr)
        begin
            q_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 8'd0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q   = q_reg;
    // a restart clears the window before the new byte shifts in
    assign fwd = clr ? 8'd0 : q_reg;

endmodule

/* hdl/eslw_walker.sv */
module eslw_walker import eslw_pkg::*; #(
    parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      acc,
    input  in_item_t  item,
    output walk_out_t walk
);

    localparam int unsigned LB = LENGTH_BITS;
    localparam int unsigned WW = ((LB > 32) ? LB : 32) + 3;

    logic [7:0] win_q   [WIN_BYTES];
    logic [7:0] win_fwd [WIN_BYTES];
    logic [7:0] view    [WIN_BYTES];

    logic start;
    logic live;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_BYTES; gi++)
        begin : g_win
            logic [7:0] din;
            if (gi == WIN_BYTES - 1)
            begin : g_last
                assign din      = item.data_byte;
                assign view[gi] = item.data_byte;
            end
            else
            begin : g_mid
                assign din      = win_fwd[gi + 1];
                assign view[gi] = win_q[gi + 1];
            end
            eslw_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clr   (start),
                .shift (live),
                .din   (din),
                .q     (win_q[gi]),
                .fwd   (win_fwd[gi])
            );
        end
    endgenerate

    logic [LB-1:0] len_reg,  len_next;
    logic [LB-1:0] pos_reg,  pos_next;
    logic [WW-1:0] lp27_reg, lp27_next;
    logic [WW-1:0] nhe_reg,  nhe_next;
    logic [WW-1:0] le_reg,   le_next;
    logic [WW-1:0] ncs_reg,  ncs_next;
    logic [WW-1:0] aend_reg, aend_next;
    logic [31:0]   stride_reg, stride_next;
    logic          pend_reg, pend_next;
    logic          stop_reg, stop_next;
    logic [23:0]   cnt_reg,  cnt_next;

    logic          stg_v_reg, stg_v_next;
    logic [WW-1:0] stg_area_reg, stg_area_next;
    logic [WW-1:0] stg_le_reg,   stg_le_next;
    logic [31:0]   stg_ss_reg,   stg_ss_next;

    logic [LB-1:0] len_in, len_cur, pos_cur;
    logic [WW-1:0] nhe_cur, lp27_cur, pos_w, pos_ls, area_ss, area_ss2;
    logic          stop_cur, pend_cur, hit, dec, bad, ok, sum, stop_after;
    logic          trailing, resolve, fit;
    logic [23:0]   cnt_cur, cnt_after;
    logic [31:0]   ls, hs, ss;
    logic [1:0]    status;

    assign start    = acc && item.start_of_file;
    assign len_in   = LB'(item.file_length);
    assign len_cur  = start ? len_in : len_reg;
    assign pos_cur  = start ? '0 : pos_reg;
    assign nhe_cur  = start ? WW'(FIRST_HDR_END) : nhe_reg;
    assign lp27_cur = start ? (WW'(len_in) + WW'(WIN_BYTES - 1)) : lp27_reg;
    assign stop_cur = start ? 1'b0 : stop_reg;
    assign pend_cur = start ? 1'b0 : pend_reg;
    assign cnt_cur  = start ? 24'd0 : cnt_reg;
    assign pos_w    = WW'(pos_cur);

    assign live = acc && (pos_cur < len_cur);

    assign ls = {view[19], view[18], view[17], view[16]};
    assign hs = {view[23], view[22], view[21], view[20]};
    assign ss = {view[27], view[26], view[25], view[24]};

    assign hit    = live && !stop_cur && pend_cur && (pos_w == ncs_reg);
    assign dec    = live && !stop_cur && (pos_w == nhe_cur);
    assign pos_ls = pos_w + WW'(ls);
    assign bad    = (ls == 32'd0) || (pos_ls > lp27_reg);
    assign ok     = !bad && (view[0] == X509_TAG) && (ss > 32'(GUID_BYTES))
                    && ((WW'(hs) + WW'(WIN_BYTES)) <= WW'(ls));

    assign sum        = live && (((LB + 1)'(pos_cur) + (LB + 1)'(1)) == (LB + 1)'(len_cur));
    assign stop_after = stop_cur || (dec && bad);
    assign trailing   = dec ? (pos_ls < lp27_reg) : (nhe_cur < lp27_cur);
    assign cnt_after  = hit ? (cnt_cur + 24'd1) : cnt_cur;

    always_comb
    begin
        if (stop_after)
        begin
            status = ST_BAD_SIZE;
        end
        else if (len_cur < LB'(ATTR_BYTES + WIN_BYTES))
        begin
            status = ST_SHORT;
        end
        else if (trailing)
        begin
            status = ST_TRAILING;
        end
        else
        begin
            status = ST_COMPLETE;
        end
    end

    // second half of a header decode, in the cycle after the header byte
    assign resolve  = stg_v_reg && !start && !dec;
    assign area_ss  = stg_area_reg + WW'(stg_ss_reg);
    assign area_ss2 = stg_area_reg + (WW'(stg_ss_reg) << 1);
    assign fit      = area_ss <= stg_le_reg;

    always_comb
    begin
        len_next      = len_cur;
        pos_next      = live ? (pos_cur + LB'(1)) : pos_cur;
        lp27_next     = lp27_cur;
        nhe_next      = nhe_cur;
        le_next       = le_reg;
        ncs_next      = ncs_reg;
        aend_next     = aend_reg;
        stride_next   = stride_reg;
        pend_next     = pend_cur;
        stop_next     = stop_after;
        cnt_next      = cnt_after;
        stg_v_next    = dec && ok;
        stg_area_next = pos_w + WW'(hs) + WW'(1);
        stg_le_next   = pos_ls - WW'(WIN_BYTES - 1);
        stg_ss_next   = ss;

        if (hit)
        begin
            if (aend_reg > le_reg)
            begin
                pend_next = 1'b0;
            end
            else
            begin
                ncs_next  = ncs_reg + WW'(stride_reg);
                aend_next = aend_reg + WW'(stride_reg);
            end
        end
        if (dec)
        begin
            pend_next = 1'b0;
            if (!bad)
            begin
                nhe_next = pos_ls;
            end
        end
        if (resolve && fit)
        begin
            pend_next   = 1'b1;
            le_next     = stg_le_reg;
            ncs_next    = stg_area_reg + WW'(GUID_BYTES);
            aend_next   = area_ss2;
            stride_next = stg_ss_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pos_reg    <= '0;
            lp27_reg   <= WW'(WIN_BYTES - 1);
            nhe_reg    <= WW'(FIRST_HDR_END);
            le_reg     <= '0;
            ncs_reg    <= '0;
            aend_reg   <= '0;
            stride_reg <= '0;
            pend_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            cnt_reg    <= '0;
            stg_v_reg  <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            lp27_reg   <= lp27_next;
            nhe_reg    <= nhe_next;
            le_reg     <= le_next;
            ncs_reg    <= ncs_next;
            aend_reg   <= aend_next;
            stride_reg <= stride_next;
            pend_reg   <= pend_next;
            stop_reg   <= stop_next;
            cnt_reg    <= cnt_next;
            stg_v_reg  <= stg_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_area_reg <= stg_area_next;
        stg_le_reg   <= stg_le_next;
        stg_ss_reg   <= stg_ss_next;
    end

    always_comb
    begin
        walk.cert_v            = hit;
        walk.sum_v             = sum;
        walk.cert.result_kind  = KIND_CERT;
        walk.cert.entry_offset = 24'(pos_cur);
        walk.cert.entry_size   = 24'(stride_reg - 32'(GUID_BYTES));
        walk.cert.cert_total   = 24'd0;
        walk.cert.file_status  = ST_COMPLETE;
        walk.cert.last_result  = !sum;
        walk.sum.result_kind   = KIND_SUMMARY;
        walk.sum.entry_offset  = 24'd0;
        walk.sum.entry_size    = 24'd0;
        walk.sum.cert_total    = cnt_after;
        walk.sum.file_status   = status;
        walk.sum.last_result   = 1'b1;
    end

endmodule

/* hdl/efi_signature_list_walker.sv */
// Each result item is registered in the result buffer before it is offered.
// Throughput: one byte per cycle; the per-byte walker step and a 28-cell
// shift window set it. A byte causes at most two results; while ready, they
// drain one per cycle from a four-entry result buffer; input stalls above two.
// Reset: window, counters, walk state and result buffer clear at once.
module efi_signature_list_walker import eslw_pkg::*; #(
    parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
    input logic        clk,
    input logic        rst_n,
    eslw_in_if.sink    byte_stream,
    eslw_out_if.source results
);

    localparam int unsigned CW = FIFO_PTR_BITS + 1;

    walk_out_t walk;
    logic      acc;
    logic      pop;
    logic      push0;
    logic      push_two;
    logic [1:0] push_n;
    res_t      item0;

    res_t                   fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    assign byte_stream.ready = cnt_reg <= CW'(FIFO_DEPTH - 2);
    assign acc = byte_stream.valid && byte_stream.ready;

    eslw_walker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .item  (byte_stream.data),
        .walk  (walk)
    );

    assign push0    = walk.cert_v || walk.sum_v;
    assign push_two = walk.cert_v && walk.sum_v;
    assign push_n   = {1'b0, push0} + {1'b0, push_two};
    assign item0    = walk.cert_v ? walk.cert : walk.sum;
    assign pop      = results.valid && results.ready;

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
    assign cnt_next    = cnt_reg + CW'(push_n) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_mem_reg[wr_ptr_reg] <= item0;
        end
        if (push_two)
        begin
            fifo_mem_reg[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= walk.sum;
        end
    end

    assign results.valid = cnt_reg != '0;
    assign results.data  = fifo_mem_reg[rd_ptr_reg];

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("result buffer count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (walk.cert_v || walk.sum_v) |-> (cnt_reg <= CW'(FIFO_DEPTH - 2)))
        else $error("result pushed without room");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |->
            (results.data.result_kind != KIND_SUMMARY || results.data.last_result))
        else $error("summary item not marked last");

    a_cert_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (walk.cert_v && !walk.sum_v) |=> !walk.cert_v)
        else $error("certificate items on adjacent cycles");

endmodule

/* verif/walk_checker.sv */
`timescale 1ns / 100ps

module walk_checker import eslw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    eslw_in_if   byte_stream,
    eslw_out_if  results,
    output int   fails,
    output int   pending
);

    typedef logic [63:0] pos_t;

    logic [7:0]  hdr_win [WIN_BYTES];
    pos_t        at_byte;
    pos_t        file_len;
    pos_t        hdr_last;
    pos_t        list_stop;
    pos_t        cert_next;
    pos_t        stride;
    logic        more_certs;
    logic [23:0] n_certs;
    logic [1:0]  walk_st;
    res_t        expected_results [$];

    function automatic pos_t win_le32(input int unsigned at);
        return {32'd0, hdr_win[at + 3], hdr_win[at + 2], hdr_win[at + 1], hdr_win[at]};
    endfunction

    task automatic clear_walk();
        foreach (hdr_win[i])
            hdr_win[i] = 8'h00;
        at_byte    = '0;
        hdr_last   = pos_t'(FIRST_HDR_END);
        list_stop  = '0;
        cert_next  = '0;
        stride     = '0;
        more_certs = 1'b0;
        n_certs    = '0;
        walk_st    = ST_COMPLETE;
    endtask

    task automatic decode_list_header(input pos_t pos);
        pos_t hd;
        pos_t ls;
        pos_t hs;
        pos_t ss;
        pos_t area;
        hd = pos - (WIN_BYTES - 1);
        ls = win_le32(16);
        hs = win_le32(20);
        ss = win_le32(24);
        more_certs = 1'b0;
        if (ls == 0 || hd + ls > file_len)
        begin
            walk_st = ST_BAD_SIZE;
            return;
        end
        list_stop = hd + ls;
        hdr_last  = list_stop + (WIN_BYTES - 1);
        if (hdr_win[0] == X509_TAG && ss > GUID_BYTES && WIN_BYTES + hs <= ls)
        begin
            area = hd + WIN_BYTES + hs;
            if (area + ss <= list_stop)
            begin
                more_certs = 1'b1;
                cert_next  = area + GUID_BYTES;
                stride     = ss;
            end
        end
    endtask

    task automatic walk_byte(input in_item_t it);
        pos_t pos;
        pos_t nxt;
        res_t cert_r;
        res_t sum_r;
        logic has_cert;
        logic has_sum;
        has_cert = 1'b0;
        has_sum  = 1'b0;
        cert_r   = '0;
        sum_r    = '0;
        if (it.start_of_file)
        begin
            clear_walk();
            file_len = pos_t'(it.file_length);
        end
        if (at_byte >= file_len)
            return;
        pos = at_byte;
        for (int i = 0; i < WIN_BYTES - 1; i++)
            hdr_win[i] = hdr_win[i + 1];
        hdr_win[WIN_BYTES - 1] = it.data_byte;

        if (walk_st == ST_COMPLETE && more_certs && pos == cert_next)
        begin
            has_cert            = 1'b1;
            cert_r.result_kind  = KIND_CERT;
            cert_r.entry_offset = pos[23:0];
            cert_r.entry_size   = 24'(stride - GUID_BYTES);
            n_certs             = n_certs + 1'b1;
            nxt                 = cert_next + stride;
            if (nxt - GUID_BYTES + stride > list_stop)
                more_certs = 1'b0;
            else
                cert_next = nxt;
        end

        if (walk_st == ST_COMPLETE && pos == hdr_last)
            decode_list_header(pos);

        at_byte = pos + 1;

        if (at_byte == file_len)
        begin
            has_sum           = 1'b1;
            sum_r.result_kind = KIND_SUMMARY;
            sum_r.cert_total  = n_certs;
            if (walk_st == ST_BAD_SIZE)
                sum_r.file_status = ST_BAD_SIZE;
            else if (file_len < ATTR_BYTES + WIN_BYTES)
                sum_r.file_status = ST_SHORT;
            else if (hdr_last - (WIN_BYTES - 1) < file_len)
                sum_r.file_status = ST_TRAILING;
            else
                sum_r.file_status = ST_COMPLETE;
        end

        if (has_sum)
            sum_r.last_result = 1'b1;
        else if (has_cert)
            cert_r.last_result = 1'b1;
        if (has_cert)
            expected_results.insert(expected_results.size(), cert_r);
        if (has_sum)
            expected_results.insert(expected_results.size(), sum_r);
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (expected_results.size() == 0)
        begin
            $error("result_kind: expected none, got %0d (offset %0d, total %0d)",
                   got.result_kind, got.entry_offset, got.cert_total);
            fails++;
            return;
        end
        want = expected_results.pop_front();
        check_field("result_kind", 24'(want.result_kind), 24'(got.result_kind));
        check_field("entry_offset", want.entry_offset, got.entry_offset);
        check_field("entry_size", want.entry_size, got.entry_size);
        check_field("cert_total", want.cert_total, got.cert_total);
        check_field("file_status", 24'(want.file_status), 24'(got.file_status));
        check_field("last_result", 24'(want.last_result), 24'(got.last_result));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_walk();
            file_len = '0;
            expected_results.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (byte_stream.valid && byte_stream.ready)
                walk_byte(byte_stream.data);
            if (results.valid && results.ready)
                check_result(results.data);
            pending = expected_results.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import eslw_pkg::*;

    localparam int unsigned RANDOM_BYTES = 250;

    logic       clk;
    logic       rst_n;
    int         fails;
    int         pending;
    int         fed;
    logic       tx_calm;
    logic [7:0] img [$];

    eslw_in_if  byte_stream ();
    eslw_out_if results ();

    efi_signature_list_walker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .results     (results)
    );

    walk_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .results     (results),
        .fails       (fails),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #8ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : drain
        int   stall;
        logic rx_calm;
        rx_calm       = 1'b0;
        results.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results.valid && results.ready));
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof, input logic [23:0] len);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            byte_stream.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_stream.valid <= 1'b1;
        byte_stream.data  <= '{data_byte: b, start_of_file: sof, file_length: len};
        do
            @(posedge clk);
        while (!(byte_stream.valid && byte_stream.ready));
        @(negedge clk);
    endtask

    task automatic send_image(input int unsigned flen);
        tx_calm = ($urandom_range(0, 3) == 0);
        foreach (img[i])
            send_byte(img[i], i == 0, (i == 0) ? flen[23:0] : 24'($urandom));
        fed += (img.size() < flen) ? img.size() : flen;
        img.delete();
    endtask

    task automatic hold_until_drained();
        byte_stream.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic put_random(input int unsigned n);
        repeat (n) img.insert(img.size(), 8'($urandom));
    endtask

    task automatic put_le32(input logic [31:0] v);
        img.insert(img.size(), v[7:0]);
        img.insert(img.size(), v[15:8]);
        img.insert(img.size(), v[23:16]);
        img.insert(img.size(), v[31:24]);
    endtask

    task automatic put_header(input logic [7:0] tag, input logic [31:0] ls,
                              input logic [31:0] hs, input logic [31:0] ss);
        img.insert(img.size(), tag);
        put_random(GUID_BYTES - 1);
        put_le32(ls);
        put_le32(hs);
        put_le32(ss);
    endtask

    task automatic put_list(input logic [7:0] tag, input int unsigned hs, input int unsigned ss,
                            input int unsigned n, input int unsigned slack);
        put_header(tag, WIN_BYTES + hs + n * ss + slack, hs, ss);
        put_random(hs + n * ss + slack);
    endtask

    function automatic logic [7:0] other_tag();
        logic [7:0] t;
        do
            t = 8'($urandom);
        while (t == X509_TAG);
        return t;
    endfunction

    task automatic put_some_list();
        int unsigned pick;
        int unsigned ss;
        int unsigned body;
        pick = $urandom_range(0, 99);
        body = $urandom_range(0, 20);
        if (pick < 65)
        begin
            ss = ($urandom_range(0, 3) == 0) ? GUID_BYTES + 1 : $urandom_range(17, 40);
            put_list(X509_TAG, $urandom_range(0, 6), ss, $urandom_range(1, 3),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, ss - 1) : 0);
        end
        else if (pick < 75)
            put_list(other_tag(), $urandom_range(0, 4), $urandom_range(17, 30),
                     $urandom_range(1, 2), 0);
        else if (pick < 85)
            put_list(X509_TAG, $urandom_range(0, 4), $urandom_range(0, GUID_BYTES),
                     $urandom_range(0, 3), $urandom_range(0, 4));
        else if (pick < 95)
        begin
            put_header(X509_TAG, WIN_BYTES + body,
                       ($urandom_range(0, 1) == 0) ? body + $urandom_range(1, 40)
                                                   : $urandom | 32'h8000_0000,
                       $urandom_range(17, 40));
            put_random(body);
        end
        else
        begin
            put_header(X509_TAG, WIN_BYTES + body, 0, $urandom | 32'h4000_0000);
            put_random(body);
        end
    endtask

    task automatic put_bad_list();
        int unsigned body;
        logic [31:0] ls;
        body = $urandom_range(0, 24);
        case ($urandom_range(0, 2))
            0:       ls = 0;
            1:       ls = WIN_BYTES + body + $urandom_range(1, 60);
            default: ls = $urandom | 32'h8000_0000;
        endcase
        put_header(($urandom_range(0, 1) == 0) ? X509_TAG : other_tag(), ls,
                   $urandom_range(0, 4), $urandom_range(17, 40));
        put_random(body);
    endtask

    task automatic random_file();
        int unsigned pick;
        int unsigned flen;
        int unsigned cut;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            put_random($urandom_range(1, ATTR_BYTES + WIN_BYTES - 1));
            send_image(img.size());
            return;
        end
        put_random(ATTR_BYTES);
        repeat ($urandom_range(1, 3)) put_some_list();
        if (pick < 22)
            put_random($urandom_range(1, WIN_BYTES - 1));
        else if (pick < 32)
            put_bad_list();
        flen = img.size();
        if (pick >= 32 && pick < 38)
        begin
            cut = $urandom_range(1, flen - 1);
            while (img.size() > cut)
                void'(img.pop_back());
        end
        else if (pick >= 38 && pick < 44)
            put_random($urandom_range(1, 6));
        send_image(flen);
    endtask

    initial
    begin
        int unsigned flen;
        rst_n             = 1'b0;
        byte_stream.valid = 1'b0;
        byte_stream.data  = '0;
        tx_calm           = 1'b1;
        fed               = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no file open yet: ignored
        send_byte(8'h00, 1'b0, 24'hFFFFFF);
        send_byte(8'hFF, 1'b0, 24'h000000);

        img.insert(img.size(), 8'hFF);
        send_image(1);

        // zero length file: ignored
        img.insert(img.size(), 8'h00);
        img.insert(img.size(), 8'hFF);
        send_image(0);

        put_random(ATTR_BYTES);
        put_list(X509_TAG, 0, GUID_BYTES + 1, 2, 0);
        put_list(8'h30, 2, 20, 1, 0);
        put_list(X509_TAG, 3, 40, 1, 25);
        send_image(img.size());

        put_random(ATTR_BYTES);
        put_list(X509_TAG, 0, GUID_BYTES, 1, 0);
        put_list(X509_TAG, 1, 0, 0, 2);
        put_header(X509_TAG, WIN_BYTES + 4, 5, GUID_BYTES + 1);
        put_random(4);
        put_random(10);
        send_image(img.size());

        put_random(ATTR_BYTES);
        put_list(X509_TAG, 0, 18, 1, 0);
        put_header(X509_TAG, 0, 0, GUID_BYTES + 1);
        put_random(3);
        send_image(img.size());

        put_random(ATTR_BYTES);
        put_header(X509_TAG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_random(2);
        send_image(img.size());

        // cut short by the next start of file
        put_random(ATTR_BYTES);
        put_list(X509_TAG, 0, GUID_BYTES + 1, 1, 0);
        send_image(24'hFFFFFF);

        put_random(ATTR_BYTES + WIN_BYTES - 1);
        send_image(img.size());

        put_random(ATTR_BYTES);
        put_list(X509_TAG, 0, 0, 0, 0);
        flen = img.size();
        put_random(3);
        send_image(flen);

        hold_until_drained();

        fed = 0;
        while (fed < RANDOM_BYTES)
        begin
            random_file();
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (16) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
hdl/eslw_pkg.sv
hdl/eslw_in_if.sv
hdl/eslw_out_if.sv
hdl/eslw_cell.sv
hdl/eslw_walker.sv
hdl/efi_signature_list_walker.sv
verif/walk_checker.sv
verif/tb.sv
